// ----- rtl/core/lscr_pkg.sv -----
// ----------------------------------------------------------------------------
// lscr_pkg
// Shared types, constants and colour ramp tables for the stretch core.
// ----------------------------------------------------------------------------
package lscr_pkg;

   // Default widths
   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Register map: index of each register, byte address is 4*index
   localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
   localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
   localparam logic [1:0] REG_NODATA     = 2'd2;
   localparam logic [1:0] REG_RAMP_SEL   = 2'd3;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Reset value of range_high before truncation to the sample width
   localparam logic [31:0] RANGE_HIGH_RESET = 32'd255;

   // Colour ramps
   typedef enum logic [1:0] {
      RAMP_GRAY  = 2'd0,
      RAMP_VEG   = 2'd1,
      RAMP_WATER = 2'd2,
      RAMP_HEAT  = 2'd3
   } ramp_type;

   // Channel indexes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam logic [7:0] LEVEL_FULL  = 8'd255;
   localparam logic [7:0] LEVEL_BROWN = 8'd139;
   localparam logic [7:0] LEVEL_OLIVE = 8'd90;
   localparam logic [7:0] LEVEL_DARK  = 8'd43;
   localparam logic [7:0] LEVEL_DEEP  = 8'd200;
   localparam logic [7:0] LEVEL_NONE  = 8'd0;

   // Control flags that travel alongside every word in the pipeline
   typedef struct packed {
      logic valid;
      logic missing;   // sample matched the no-data value
      logic zero;      // position forced to zero
      logic full;      // position saturated at one
      logic last;      // frame end marker
   } lscr_flags_type;

   // Start colour of a ramp, per channel
   function automatic logic [7:0] ramp_start(input ramp_type sel, input logic [1:0] ch);
      logic [7:0] lvl;
      lvl = LEVEL_NONE;
      case (sel)
         RAMP_GRAY: lvl = LEVEL_NONE;
         RAMP_VEG: begin
            case (ch)
               CH_RED:   lvl = LEVEL_BROWN;
               CH_GREEN: lvl = LEVEL_OLIVE;
               default:  lvl = LEVEL_DARK;
            endcase
         end
         RAMP_WATER: lvl = LEVEL_FULL;
         RAMP_HEAT:  lvl = (ch == CH_BLUE) ? LEVEL_FULL : LEVEL_NONE;
         default:    lvl = LEVEL_NONE;
      endcase
      return lvl;
   endfunction

   // End colour of a ramp, per channel
   function automatic logic [7:0] ramp_end(input ramp_type sel, input logic [1:0] ch);
      logic [7:0] lvl;
      lvl = LEVEL_NONE;
      case (sel)
         RAMP_GRAY:  lvl = LEVEL_FULL;
         RAMP_VEG:   lvl = (ch == CH_GREEN) ? LEVEL_DEEP : LEVEL_NONE;
         RAMP_WATER: lvl = (ch == CH_BLUE) ? LEVEL_DEEP : LEVEL_NONE;
         RAMP_HEAT:  lvl = (ch == CH_RED) ? LEVEL_FULL : LEVEL_NONE;
         default:    lvl = LEVEL_NONE;
      endcase
      return lvl;
   endfunction

endpackage

// ----- rtl/core/lscr_front.sv -----
// ----------------------------------------------------------------------------
// lscr_front
// Entry stage: no-data match, range offset and span, saturation decision.
// ----------------------------------------------------------------------------
module lscr_front #(
   parameter int SAMPLE_BITS = lscr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic                          in_last,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic [SAMPLE_BITS-1:0]        range_low,
   input  logic [SAMPLE_BITS-1:0]        range_high,
   input  logic [SAMPLE_BITS-1:0]        nodata_value,
   output lscr_pkg::lscr_flags_type      flags_out,
   output logic [SAMPLE_BITS-1:0]        rem_out,
   output logic [SAMPLE_BITS-1:0]        span_out
);

   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [SAMPLE_BITS:0]   span;
   logic                          range_ok;
   logic                          zero;
   logic                          full;
   lscr_pkg::lscr_flags_type      flags_in;
   lscr_pkg::lscr_flags_type      flags_ff;
   logic [SAMPLE_BITS-1:0]        rem_ff;
   logic [SAMPLE_BITS-1:0]        span_ff;

   always_comb begin
      diff     = $signed({sample[SAMPLE_BITS-1], sample})
               - $signed({range_low[SAMPLE_BITS-1], range_low});
      span     = $signed({range_high[SAMPLE_BITS-1], range_high})
               - $signed({range_low[SAMPLE_BITS-1], range_low});
      range_ok = $signed(range_high) > $signed(range_low);
      zero     = !range_ok || (diff <= 0);
      full     = !zero && (diff >= span);

      flags_in.valid   = in_valid;
      flags_in.missing = (sample == nodata_value);
      flags_in.zero    = zero;
      flags_in.full    = full;
      flags_in.last    = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.valid <= 1'b0;
      end else if (advance) begin
         flags_ff.valid <= flags_in.valid;
      end
   end

   // payload: remainder starts at the offset, which is below the span when dividing
   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff.missing <= flags_in.missing;
         flags_ff.zero    <= flags_in.zero;
         flags_ff.full    <= flags_in.full;
         flags_ff.last    <= flags_in.last;
         rem_ff           <= diff[SAMPLE_BITS-1:0];
         span_ff          <= span[SAMPLE_BITS-1:0];
      end
   end

   assign flags_out = flags_ff;
   assign rem_out   = rem_ff;
   assign span_out  = span_ff;

endmodule

// ----- rtl/core/lscr_div_cell.sv -----
// ----------------------------------------------------------------------------
// lscr_div_cell
// One restoring-division step: produce one quotient bit and pass on.
// ----------------------------------------------------------------------------
module lscr_div_cell #(
   parameter int SAMPLE_BITS   = lscr_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = lscr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  lscr_pkg::lscr_flags_type      flags_in,
   input  logic [SAMPLE_BITS-1:0]        rem_in,
   input  logic [SAMPLE_BITS-1:0]        span_in,
   input  logic [FRACTION_BITS-1:0]      quot_in,
   output lscr_pkg::lscr_flags_type      flags_out,
   output logic [SAMPLE_BITS-1:0]        rem_out,
   output logic [SAMPLE_BITS-1:0]        span_out,
   output logic [FRACTION_BITS-1:0]      quot_out
);

   logic [SAMPLE_BITS:0]          rem_dbl;
   logic [SAMPLE_BITS:0]          rem_sub;
   logic                          take;
   lscr_pkg::lscr_flags_type      flags_ff;
   logic [SAMPLE_BITS-1:0]        rem_ff;
   logic [SAMPLE_BITS-1:0]        span_ff;
   logic [FRACTION_BITS-1:0]      quot_ff;
   logic [SAMPLE_BITS-1:0]        rem_in_next;

   always_comb begin
      rem_dbl     = {rem_in, 1'b0};
      rem_sub     = rem_dbl - {1'b0, span_in};
      take        = rem_dbl >= {1'b0, span_in};
      // remainder stays below the span, so it fits the sample width
      rem_in_next = take ? rem_sub[SAMPLE_BITS-1:0] : rem_dbl[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.valid <= 1'b0;
      end else if (advance) begin
         flags_ff.valid <= flags_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff.missing <= flags_in.missing;
         flags_ff.zero    <= flags_in.zero;
         flags_ff.full    <= flags_in.full;
         flags_ff.last    <= flags_in.last;
         rem_ff           <= rem_in_next;
         span_ff          <= span_in;
         quot_ff          <= {quot_in[FRACTION_BITS-2:0], take};
      end
   end

   assign flags_out = flags_ff;
   assign rem_out   = rem_ff;
   assign span_out  = span_ff;
   assign quot_out  = quot_ff;

endmodule

// ----- rtl/core/lscr_ramp.sv -----
// ----------------------------------------------------------------------------
// lscr_ramp
// Output stage: position select, colour interpolation, output register.
// ----------------------------------------------------------------------------
module lscr_ramp #(
   parameter int FRACTION_BITS = lscr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  lscr_pkg::lscr_flags_type      flags_in,
   input  logic [FRACTION_BITS-1:0]      quot_in,
   input  lscr_pkg::ramp_type            ramp_select,
   output logic                          out_valid,
   output logic [7:0]                    red,
   output logic [7:0]                    green,
   output logic [7:0]                    blue,
   output logic                          is_missing,
   output logic                          end_of_frame
);

   localparam int AW = FRACTION_BITS + 11;

   logic [FRACTION_BITS:0]        pos;
   logic signed [FRACTION_BITS+1:0] pos_s;
   logic [7:0]                    level [3];
   logic                          valid_ff;
   logic [7:0]                    level_ff [3];
   logic                          missing_ff;
   logic                          last_ff;

   always_comb begin
      if (flags_in.zero) begin
         pos = '0;
      end else if (flags_in.full) begin
         pos = {1'b1, {FRACTION_BITS{1'b0}}};
      end else begin
         pos = {1'b0, quot_in};
      end
      pos_s = $signed({1'b0, pos});
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [7:0]             c_start;
      logic [7:0]             c_end;
      logic signed [8:0]      delta;
      logic signed [AW-1:0]   prod;
      logic signed [AW-1:0]   acc;

      always_comb begin
         c_start = lscr_pkg::ramp_start(ramp_select, 2'(ch));
         c_end   = lscr_pkg::ramp_end(ramp_select, 2'(ch));
         delta   = $signed({1'b0, c_end}) - $signed({1'b0, c_start});
         // widen both factors first so the product keeps all its bits
         prod    = AW'(delta) * AW'(pos_s);
         acc     = $signed({3'b000, c_start, {FRACTION_BITS{1'b0}}}) + prod;
         // missing samples come out black
         level[ch] = flags_in.missing ? 8'd0 : acc[FRACTION_BITS+7:FRACTION_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= flags_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff   <= level;
         missing_ff <= flags_in.missing;
         last_ff    <= flags_in.last;
      end
   end

   assign out_valid    = valid_ff;
   assign red          = level_ff[0];
   assign green        = level_ff[1];
   assign blue         = level_ff[2];
   assign is_missing   = missing_ff;
   assign end_of_frame = last_ff;

endmodule

// ----- rtl/core/linear_stretch_color_ramp_core.sv -----
// ----------------------------------------------------------------------------
// linear_stretch_color_ramp_core
// Linear contrast stretch of signed raster samples onto a colour ramp.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while not stalled and returns one RGB
// word per sample through a pipeline FRACTION_BITS + 2 registers deep.
// A sample equal to nodata_value comes out black with is_missing set. Any
// other sample is placed on [range_low, range_high] as a Q1.FRACTION_BITS
// position, clamped to 0..1 (an empty or inverted range gives 0), and the
// selected ramp is interpolated per channel. Most of the depth is the
// division row: one cell per position bit, each cell producing one quotient
// bit and passing its remainder to the next. The whole row advances together;
// it stalls only while a result sits in the output register and rsp_tready is
// low, so a steady one word per clock flows when the sink keeps up.
// Registers (byte address): range_low 0x0, range_high 0x4, nodata_value 0x8,
// ramp_select 0xC. Write them only while the core holds no work.
// ----------------------------------------------------------------------------
module linear_stretch_color_ramp_core #(
   parameter int SAMPLE_BITS   = lscr_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = lscr_pkg::FRACTION_BITS_DEFAULT,
   localparam int IN_BYTES_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [IN_BYTES_W-1:0]                  req_tdata,  // [SAMPLE_BITS-1:0] sample
   input  logic                                   req_tlast,  // frame_end
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [23:0]                            rsp_tdata,  // [7:0] red, [15:8] green, [23:16] blue
   output logic                                   rsp_tuser,  // is_missing
   output logic                                   rsp_tlast,  // end_of_frame
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lscr_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [lscr_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [lscr_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   logic                          advance;
   logic                          csr_write;
   logic [1:0]                    csr_index;
   logic [SAMPLE_BITS-1:0]        range_low_ff;
   logic [SAMPLE_BITS-1:0]        range_high_ff;
   logic [SAMPLE_BITS-1:0]        nodata_ff;
   lscr_pkg::ramp_type            ramp_sel_ff;

   lscr_pkg::lscr_flags_type      flags  [FRACTION_BITS+1];
   logic [SAMPLE_BITS-1:0]        rem    [FRACTION_BITS+1];
   logic [SAMPLE_BITS-1:0]        span   [FRACTION_BITS+1];
   logic [FRACTION_BITS-1:0]      quot   [FRACTION_BITS+1];

   logic [7:0]                    red;
   logic [7:0]                    green;
   logic [7:0]                    blue;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= lscr_pkg::RANGE_HIGH_RESET[SAMPLE_BITS-1:0];
         nodata_ff     <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         ramp_sel_ff   <= lscr_pkg::RAMP_GRAY;
      end else if (csr_write) begin
         case (csr_index)
            lscr_pkg::REG_RANGE_LOW:  range_low_ff  <= csr_pwdata[SAMPLE_BITS-1:0];
            lscr_pkg::REG_RANGE_HIGH: range_high_ff <= csr_pwdata[SAMPLE_BITS-1:0];
            lscr_pkg::REG_NODATA:     nodata_ff     <= csr_pwdata[SAMPLE_BITS-1:0];
            lscr_pkg::REG_RAMP_SEL:   ramp_sel_ff   <= lscr_pkg::ramp_type'(csr_pwdata[1:0]);
            default: ;
         endcase
      end
   end

   // read back: zero-extend to the bus width
   always_comb begin
      case (csr_index)
         lscr_pkg::REG_RANGE_LOW:  csr_prdata = lscr_pkg::CSR_DATA_BITS'(range_low_ff);
         lscr_pkg::REG_RANGE_HIGH: csr_prdata = lscr_pkg::CSR_DATA_BITS'(range_high_ff);
         lscr_pkg::REG_NODATA:     csr_prdata = lscr_pkg::CSR_DATA_BITS'(nodata_ff);
         lscr_pkg::REG_RAMP_SEL:   csr_prdata = lscr_pkg::CSR_DATA_BITS'(ramp_sel_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline
   // Advance every stage together; hold the lot while a result waits unclaimed.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   lscr_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .in_last      (req_tlast),
      .sample       (req_tdata[SAMPLE_BITS-1:0]),
      .range_low    (range_low_ff),
      .range_high   (range_high_ff),
      .nodata_value (nodata_ff),
      .flags_out    (flags[0]),
      .rem_out      (rem[0]),
      .span_out     (span[0])
   );

   // quotient starts empty and fills one bit per cell, most significant first
   assign quot[0] = '0;

   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
      lscr_div_cell #(
         .SAMPLE_BITS   (SAMPLE_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .flags_in  (flags[i]),
         .rem_in    (rem[i]),
         .span_in   (span[i]),
         .quot_in   (quot[i]),
         .flags_out (flags[i+1]),
         .rem_out   (rem[i+1]),
         .span_out  (span[i+1]),
         .quot_out  (quot[i+1])
      );
   end

   lscr_ramp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ramp (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .flags_in     (flags[FRACTION_BITS]),
      .quot_in      (quot[FRACTION_BITS]),
      .ramp_select  (ramp_sel_ff),
      .out_valid    (rsp_tvalid),
      .red          (red),
      .green        (green),
      .blue         (blue),
      .is_missing   (rsp_tuser),
      .end_of_frame (rsp_tlast)
   );

   assign rsp_tdata = {blue, green, red};

   // ---------------------------------------------------------------- checks
   a_missing_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("missing sample did not come out black");

   a_zero_full_excl: assert property (@(posedge clock) disable iff (reset)
      flags[0].valid |-> !(flags[0].zero && flags[0].full))
      else $error("position both forced to zero and saturated");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      flags[FRACTION_BITS].valid && !flags[FRACTION_BITS].zero
      && !flags[FRACTION_BITS].full |-> rem[FRACTION_BITS] < span[FRACTION_BITS])
      else $error("division remainder reached the span");

   a_stall_holds_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(quot[FRACTION_BITS])
      && $stable(flags[FRACTION_BITS]))
      else $error("division row moved during a stall");

endmodule

// ----- tb/colour_ramp_checker.sv -----
// ----------------------------------------------------------------------------
// colour_ramp_checker
// Watches the sample, pixel and register ports of the stretch core.
// ----------------------------------------------------------------------------
// Mirrors the register writes and predicts one pixel for every accepted
// sample word. Each pixel word is compared field by field with the oldest
// prediction. Register reads are compared with the mirrored values.
// ----------------------------------------------------------------------------
module colour_ramp_checker
   import lscr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tlast,   // frame_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic        rsp_tuser,   // is_missing
   input  logic        rsp_tlast,   // end_of_frame
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pixels_checked,
   output int          pixels_pending
);

   localparam int POS_BITS = FRACTION_BITS_DEFAULT;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       missing;
      logic       last;
   } pixel_type;

   pixel_type pixel_queue[$];

   logic signed [15:0] low_bound;
   logic signed [15:0] high_bound;
   logic signed [15:0] nodata_mark;
   ramp_type           palette;

   initial begin
      mismatch_count = 0;
      pixels_checked = 0;
      pixels_pending = 0;
   end

   // {end blue, end green, end red, start blue, start green, start red}
   function automatic logic [47:0] ramp_ends(input ramp_type r);
      case (r)
         RAMP_GRAY:  return {8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0};
         RAMP_VEG:   return {8'd0,   8'd200, 8'd0,   8'd43,  8'd90,  8'd139};
         RAMP_WATER: return {8'd200, 8'd0,   8'd0,   8'd255, 8'd255, 8'd255};
         RAMP_HEAT:  return {8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd0};
         default:    return '0;
      endcase
   endfunction

   function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                        input longint pos);
      longint acc;
      acc = (longint'(a) <<< POS_BITS) + (longint'(b) - longint'(a)) * pos;
      if (acc < 0) begin
         acc = 0;
      end
      return 8'(acc >>> POS_BITS);
   endfunction

   function automatic pixel_type shade_sample(input logic signed [15:0] sample,
                                              input logic frame_end);
      pixel_type px;
      longint    diff;
      longint    span;
      longint    pos;
      logic [47:0] ends;
      px = '0;
      px.last = frame_end;
      if (sample == nodata_mark) begin
         px.missing = 1'b1;
         return px;
      end
      // empty or inverted range keeps the start colour
      pos = 0;
      if (high_bound > low_bound) begin
         diff = longint'(sample) - longint'(low_bound);
         span = longint'(high_bound) - longint'(low_bound);
         if (diff <= 0) begin
            pos = 0;
         end else if (diff >= span) begin
            pos = longint'(1) <<< POS_BITS;
         end else begin
            pos = (diff <<< POS_BITS) / span;
         end
      end
      ends = ramp_ends(palette);
      px.red   = blend(ends[7:0],   ends[31:24], pos);
      px.green = blend(ends[15:8],  ends[39:32], pos);
      px.blue  = blend(ends[23:16], ends[47:40], pos);
      return px;
   endfunction

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_type want;
      if (reset) begin
         low_bound   = 16'sd0;
         high_bound  = 16'sd255;
         nodata_mark = -16'sd32768;
         palette     = RAMP_GRAY;
      end else begin
         // pixel side first: a word accepted now cannot stem from this edge
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: pixel word with none expected, data %h missing %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = pixel_queue.pop_front();
               compare_field("red", {8'd0, want.red}, {8'd0, rsp_tdata[7:0]});
               compare_field("green", {8'd0, want.green}, {8'd0, rsp_tdata[15:8]});
               compare_field("blue", {8'd0, want.blue}, {8'd0, rsp_tdata[23:16]});
               compare_field("is_missing", {15'd0, want.missing}, {15'd0, rsp_tuser});
               compare_field("end_of_frame", {15'd0, want.last}, {15'd0, rsp_tlast});
               pixels_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            pixel_queue.push_back(shade_sample(req_tdata, req_tlast));
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_RANGE_LOW:  low_bound   = csr_pwdata[15:0];
                  REG_RANGE_HIGH: high_bound  = csr_pwdata[15:0];
                  REG_NODATA:     nodata_mark = csr_pwdata[15:0];
                  default:        palette     = ramp_type'(csr_pwdata[1:0]);
               endcase
            end else begin
               case (csr_paddr[3:2])
                  REG_RANGE_LOW:  compare_field("range_low read", low_bound,
                                                csr_prdata[15:0]);
                  REG_RANGE_HIGH: compare_field("range_high read", high_bound,
                                                csr_prdata[15:0]);
                  REG_NODATA:     compare_field("nodata_value read", nodata_mark,
                                                csr_prdata[15:0]);
                  default:        compare_field("ramp_select read", {14'd0, palette},
                                                {14'd0, csr_prdata[1:0]});
               endcase
            end
         end
      end
      pixels_pending = pixel_queue.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the linear stretch colour ramp core.
// ----------------------------------------------------------------------------
// Drives sample words and register settings into the core while a separate
// checker predicts every pixel. A short directed part covers the field
// extremes, no-data hits, empty and inverted ranges and all four ramps; then
// nine random phases each load a fresh setting and stream about a hundred
// samples, with random idling on both sides, one long sink stall and a calm
// closing phase.
// ----------------------------------------------------------------------------
module tb_top;
   import lscr_pkg::*;

   // pipeline is FRACTION_BITS + 2 deep; allow a little on top of that
   localparam int DRAIN_GUARD = FRACTION_BITS_DEFAULT + 8;
   localparam int SINK_HOLD   = 120;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample
   logic        req_tlast;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] red, [15:8] green, [23:16] blue
   logic        rsp_tuser;   // is_missing
   logic        rsp_tlast;   // end_of_frame
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int pixels_checked;
   int pixels_pending;

   int samples_sent  = 0;
   int settings_made = 0;
   int gap_odds      = 0;   // sender idles before one word in gap_odds; 0 means never
   int stall_odds    = 0;   // sink stalls at one pick in stall_odds; 0 means never
   bit choke_req     = 0;   // ask the sink for one long hold-off
   int cur_lo        = 0;
   int cur_hi        = 255;
   int cur_nd        = -32768;

   linear_stretch_color_ramp_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   colour_ramp_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pixels_checked (pixels_checked),
      .pixels_pending (pixels_pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // Sink: short random stalls, or one long hold-off on request so the
   // pipeline fills and the core has to drop req_tready.
   initial begin : sink
      forever begin
         if (choke_req) begin
            choke_req = 0;
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD) @(posedge clock);
         end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic int clip16(input int v);
      return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
   endfunction

   // One register access: setup phase, access phase until csr_pready, then psel
   // low before return, so back-to-back accesses never drive psel twice in a step.
   task automatic csr_access(input bit write, input logic [1:0] idx,
                             input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back();
      csr_access(1'b0, REG_RANGE_LOW, '0);
      csr_access(1'b0, REG_RANGE_HIGH, '0);
      csr_access(1'b0, REG_NODATA, '0);
      csr_access(1'b0, REG_RAMP_SEL, '0);
   endtask

   // Load all four registers; the unused upper bits carry junk, which the
   // core must ignore.
   task automatic apply_setting(input int lo, input int hi, input int nd,
                                input ramp_type r);
      cur_lo = lo;
      cur_hi = hi;
      cur_nd = nd;
      csr_access(1'b1, REG_RANGE_LOW,  {16'($urandom), 16'(lo)});
      csr_access(1'b1, REG_RANGE_HIGH, {16'($urandom), 16'(hi)});
      csr_access(1'b1, REG_NODATA,     {16'($urandom), 16'(nd)});
      csr_access(1'b1, REG_RAMP_SEL,   {30'($urandom), r});
      read_back();
      settings_made++;
   endtask

   // Offer one sample word, maybe after an idle burst, and hold it until taken.
   task automatic push_sample(input int sample, input logic last);
      if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 16'(sample);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   // Drop valid and wait until every predicted pixel is back, plus the
   // pipeline depth, so a register write finds the core idle.
   task automatic settle();
      int waited;
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pixels_pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_GUARD) @(posedge clock);
   endtask

   // Settings by style: full range, empty, inverted, narrow, else general.
   task automatic random_setting(input int style, input ramp_type r);
      int lo;
      int hi;
      int nd;
      int swap;
      lo = $urandom_range(0, 65535) - 32768;
      hi = $urandom_range(0, 65535) - 32768;
      case (style)
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: hi = lo;
         2: hi = clip16(lo - $urandom_range(1, 4000));
         3: hi = clip16(lo + $urandom_range(1, 16));
         default: begin
            if (lo > hi) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
         end
      endcase
      // half the time put the no-data mark where samples will land
      if ($urandom_range(0, 1) == 0) begin
         nd = (lo < hi) ? lo + $urandom_range(0, hi - lo) : hi + $urandom_range(0, lo - hi);
      end else begin
         nd = $urandom_range(0, 65535) - 32768;
      end
      apply_setting(lo, hi, nd, r);
   endtask

   // Mostly samples inside the range, with edges, no-data hits and noise.
   function automatic int pick_sample();
      int v;
      case ($urandom_range(0, 9))
         0: v = cur_nd;
         1, 2: v = $urandom_range(0, 65535) - 32768;
         3: begin
            case ($urandom_range(0, 5))
               0: v = cur_lo;
               1: v = cur_hi;
               2: v = cur_lo - 1;
               3: v = cur_hi + 1;
               4: v = -32768;
               default: v = 32767;
            endcase
         end
         default: begin
            if (cur_hi > cur_lo) begin
               v = cur_lo + $urandom_range(0, cur_hi - cur_lo);
            end else begin
               v = cur_lo + $urandom_range(0, 64) - 32;
            end
         end
      endcase
      return clip16(v);
   endfunction

   initial begin : stimulus
      int failures;
      int phase;
      int item;
      ramp_type r;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset       <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: 0..255 grayscale, no-data at the most negative sample
      read_back();
      gap_odds   = 4;
      stall_odds = 5;
      push_sample(-32768, 1'b0);
      push_sample(0, 1'b1);
      push_sample(255, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(128, 1'b0);
      push_sample(1, 1'b0);
      push_sample(254, 1'b1);
      push_sample(-1, 1'b0);
      push_sample(-32767, 1'b0);
      settle();

      // widest range, no-data in the middle
      apply_setting(-32768, 32767, 0, RAMP_VEG);
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b1);
      push_sample(0, 1'b0);
      push_sample(1, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(16'h5555, 1'b0);
      settle();

      // inverted range: every sample but the no-data one sits at the ramp start
      apply_setting(100, -100, 32767, RAMP_WATER);
      push_sample(0, 1'b0);
      push_sample(100, 1'b0);
      push_sample(-100, 1'b0);
      push_sample(32767, 1'b1);
      settle();

      // both range registers zero: an empty range, nothing derived
      apply_setting(0, 0, -1, RAMP_HEAT);
      push_sample(0, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(5, 1'b0);
      push_sample(-5, 1'b1);
      settle();

      apply_setting(-10, 10, -32768, RAMP_HEAT);
      push_sample(-10, 1'b0);
      push_sample(10, 1'b0);
      push_sample(0, 1'b1);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else if (phase == 2) begin
            // keep the sender busy so the long hold-off backs up the pipeline
            gap_odds   = 0;
            stall_odds = 6;
         end else begin
            gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
         end
         r = (phase < 4) ? ramp_type'(phase) : ramp_type'($urandom_range(0, 3));
         random_setting((phase < 3) ? phase : $urandom_range(3, 6), r);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 2 && item == 40) begin
               choke_req = 1;
            end
            push_sample(pick_sample(), $urandom_range(0, 7) == 0);
         end
         settle();
      end

      failures = mismatch_count + pixels_pending;
      if (pixels_pending != 0) begin
         $display("%0t: %0d expected pixels never arrived", $time, pixels_pending);
      end
      $display("Run: %0d samples sent, %0d pixels compared, %0d register settings",
               samples_sent, pixels_checked, settings_made);
      $display("Covered all ramps, full/empty/inverted ranges, no-data and one long sink stall");
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/lscr_pkg.sv
rtl/core/lscr_front.sv
rtl/core/lscr_div_cell.sv
rtl/core/lscr_ramp.sv
rtl/core/linear_stretch_color_ramp_core.sv
tb/colour_ramp_checker.sv
tb/tb_top.sv
